[rtl/rasc_pkg.sv]
// shared types and constants for the receiver auto-scan controller
package rasc_pkg;

  localparam int NUM_VFOS_DEF = 4;
  localparam int MAX_RATE_DEF = 8;

  // pacing of the scan timer in milliseconds
  localparam int STEP_MS  = 200;
  localparam int PACE_MUL = 3;
  localparam int BASE_MS  = 100;
  localparam int STEP_W   = 10;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_SELECT = 3'd4
  } op_t;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_SIMPLE = 3'd1;
  localparam logic [2:0] MODE_UP     = 3'd2;
  localparam logic [2:0] MODE_DOWN   = 3'd3;
  localparam logic [2:0] MODE_BOUNCE = 3'd4;

  localparam logic [2:0] TGT_KEEP = 3'd0;
  localparam logic [2:0] TGT_PREV = 3'd1;
  localparam logic [3:0] TGT_BASE = 4'd2;

  typedef struct packed {
    op_t         opcode;
    logic [1:0]  knob_dir;
    logic        digit_selected;
    logic [31:0] now_ms;
    logic [2:0]  scan_mode;
    logic [1:0]  start_dir;
    logic [2:0]  stop_target;
    logic [1:0]  vfo_index;
    logic [31:0] freq;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  tune_dir;
    logic [1:0]  active_vfo;
    logic [2:0]  mode_now;
    logic [31:0] scan_freq;
    logic        refresh;
    logic        accepted;
  } res_t;

endpackage

[rtl/radio_auto_scan_controller_unit.sv]
// receiver auto-scan controller: input register, command logic, result register
// an accepted command waits in the input register until the result register can
//   load, and its result is then registered in the result register
// throughput: one command per cycle, stalled while a full result register is not read
// reset: synchronous active-low rst_n clears the vfo table, scan state and pacing
module radio_auto_scan_controller_unit #(
  parameter int NUM_VFOS = rasc_pkg::NUM_VFOS_DEF,
  parameter int MAX_RATE = rasc_pkg::MAX_RATE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // opcode
  input  logic [2:0]                      in_tuser,
  // knob_dir, digit_selected, now_ms, scan_mode, start_dir, stop_target, vfo_index, freq
  input  logic [rasc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tune_dir, active_vfo, mode_now, scan_freq, refresh, accepted
  output logic [rasc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);

  logic           pace_triple_r;
  logic           pace_triple_nxt;
  logic           cmd_valid;
  rasc_pkg::cmd_t cmd;
  rasc_pkg::res_t res;
  logic           can_load;
  logic           step_en;

  assign cfg_ready       = 1'b1;
  assign pace_triple_nxt = (cfg_valid && cfg_ready) ? cfg_data : pace_triple_r;
  assign step_en         = cmd_valid && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pace_triple_r <= 1'b0;
    end else begin
      pace_triple_r <= pace_triple_nxt;
    end
  end

  rasc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .take      (step_en),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  rasc_core #(
    .NUM_VFOS (NUM_VFOS),
    .MAX_RATE (MAX_RATE)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .pace_triple (pace_triple_r),
    .cmd         (cmd),
    .res         (res)
  );

  rasc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a started scan always reports a running mode
  a_accept_mode: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.accepted |-> res.mode_now != rasc_pkg::MODE_IDLE)
    else $error("start accepted with idle mode");

  // a start that begins a scan never redraws as a stop does
  a_accept_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> !(res.accepted && res.refresh))
    else $error("accepted and refresh both set");

  // every processed command shows up as a result transaction
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_tvalid)
    else $error("processed command produced no result");

  // an empty result register never blocks the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

[rtl/rasc_in_stage.sv]
// input register: unpacks the command stream into a command struct
module rasc_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2:0]                          in_tuser,  // opcode
  input  logic [rasc_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                take,
  output logic                                cmd_valid,
  output rasc_pkg::cmd_t                      cmd
);

  logic           valid_r;
  logic           valid_nxt;
  rasc_pkg::cmd_t cmd_r;
  rasc_pkg::cmd_t cmd_nxt;

  assign in_tready = !valid_r || take;

  always_comb begin
    cmd_nxt.opcode         = rasc_pkg::op_t'(in_tuser);
    cmd_nxt.knob_dir       = in_tdata[1:0];
    cmd_nxt.digit_selected = in_tdata[2];
    cmd_nxt.now_ms         = in_tdata[34:3];
    cmd_nxt.scan_mode      = in_tdata[37:35];
    cmd_nxt.start_dir      = in_tdata[39:38];
    cmd_nxt.stop_target    = in_tdata[42:40];
    cmd_nxt.vfo_index      = in_tdata[44:43];
    cmd_nxt.freq           = in_tdata[76:45];
    valid_nxt              = (in_tvalid && in_tready) || (valid_r && !take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

[rtl/rasc_core.sv]
// scan state, vfo table and the per-command update logic
module rasc_core #(
  parameter int NUM_VFOS = rasc_pkg::NUM_VFOS_DEF,
  parameter int MAX_RATE = rasc_pkg::MAX_RATE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic           pace_triple,
  input  rasc_pkg::cmd_t cmd,
  output rasc_pkg::res_t res
);

  localparam int IDX_W  = $clog2(NUM_VFOS);
  localparam int RATE_W = $clog2(MAX_RATE + 1) + 1;
  localparam int SUM_W  = RATE_W + 2;

  localparam logic [IDX_W-1:0] VFO_A = IDX_W'(0);
  localparam logic [IDX_W-1:0] VFO_B = IDX_W'(1);
  localparam logic [IDX_W-1:0] VFO_S = IDX_W'(NUM_VFOS - 1);

  localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'(MAX_RATE);
  localparam logic signed [SUM_W-1:0] MIN_S = -MAX_S;

  function automatic logic signed [RATE_W-1:0] clamp_rate(input logic signed [SUM_W-1:0] r);
    logic signed [SUM_W-1:0] c;
    c = r;
    if (r > MAX_S) c = MAX_S;
    if (r < MIN_S) c = MIN_S;
    return RATE_W'(c);
  endfunction

  function automatic logic [1:0] sign_of(input logic signed [RATE_W-1:0] r);
    return {r[RATE_W-1], |r};
  endfunction

  logic [31:0]              freq_r [NUM_VFOS];
  logic [IDX_W-1:0]         active_r, active_nxt;
  logic [IDX_W-1:0]         stash_r, stash_nxt;
  logic                     lo_b_r, lo_b_nxt;
  logic                     hi_b_r, hi_b_nxt;
  logic [2:0]               mode_r, mode_nxt;
  logic signed [RATE_W-1:0] rate_r, rate_nxt;
  logic [31:0]              deadline_r, deadline_nxt;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [31:0]              wdata;

  logic signed [1:0]        knob;
  logic signed [1:0]        sdir;
  logic signed [RATE_W-1:0] rate_knob;
  logic signed [RATE_W-1:0] rate1;
  logic [31:0]              dl1;
  logic                     fire;
  logic [RATE_W-1:0]        abs1;
  logic signed [RATE_W-1:0] pos1;
  logic signed [RATE_W-1:0] neg1;
  logic signed [RATE_W-1:0] rate_bnc;
  logic [RATE_W-1:0]        wait_k;
  logic [rasc_pkg::STEP_W-1:0] step_ms;
  logic [31:0]              delay;
  logic [31:0]              new_dl;
  logic [31:0]              s_freq, lo_freq, hi_freq, a_freq, b_freq, act_freq;
  logic signed [SUM_W-1:0]  start_sq;
  logic signed [RATE_W-1:0] start_rate;
  logic [3:0]               tgt_off;
  logic                     go;
  logic [1:0]               tune;
  logic                     refresh;
  logic                     accepted;

  assign knob     = $signed(cmd.knob_dir);
  assign sdir     = $signed(cmd.start_dir);
  assign s_freq   = freq_r[VFO_S];
  assign a_freq   = freq_r[VFO_A];
  assign b_freq   = freq_r[VFO_B];
  assign lo_freq  = lo_b_r ? b_freq : a_freq;
  assign hi_freq  = hi_b_r ? b_freq : a_freq;
  assign act_freq = freq_r[active_r];

  // knob turn adjusts the rate and forces the timer to fire
  assign rate_knob = clamp_rate(SUM_W'(rate_r) + SUM_W'(knob));
  assign rate1     = (knob != 2'sd0) ? rate_knob : rate_r;
  assign dl1       = (knob != 2'sd0) ? 32'd0 : deadline_r;
  assign fire      = !(dl1 > cmd.now_ms);

  assign abs1    = rate1[RATE_W-1] ? RATE_W'(-rate1) : RATE_W'(rate1);
  assign pos1    = $signed(abs1);
  assign neg1    = -pos1;
  assign wait_k  = RATE_W'(MAX_RATE) - abs1;
  assign step_ms = pace_triple ? rasc_pkg::STEP_W'(rasc_pkg::STEP_MS * rasc_pkg::PACE_MUL)
                               : rasc_pkg::STEP_W'(rasc_pkg::STEP_MS);
  assign delay   = 32'(wait_k) * 32'(step_ms);
  assign new_dl  = cmd.now_ms + 32'(rasc_pkg::BASE_MS) + delay;

  always_comb begin
    rate_bnc = rate1;
    if (s_freq >= hi_freq) rate_bnc = neg1;
    if (s_freq <= lo_freq) rate_bnc = pos1;
  end

  // start rate is |d|*d, only d = -2 differs from d
  assign start_sq   = (sdir == -2'sd2) ? -SUM_W'(4) : SUM_W'(sdir);
  assign start_rate = clamp_rate(start_sq);
  assign tgt_off    = {1'b0, cmd.stop_target} - rasc_pkg::TGT_BASE;

  always_comb begin
    active_nxt   = active_r;
    stash_nxt    = stash_r;
    lo_b_nxt     = lo_b_r;
    hi_b_nxt     = hi_b_r;
    mode_nxt     = mode_r;
    rate_nxt     = rate_r;
    deadline_nxt = deadline_r;
    we           = 1'b0;
    waddr        = VFO_S;
    wdata        = cmd.freq;
    tune         = 2'b00;
    refresh      = 1'b0;
    accepted     = 1'b0;
    go           = 1'b0;
    case (cmd.opcode)
      rasc_pkg::OP_TICK: begin
        if (mode_r == rasc_pkg::MODE_IDLE) begin
          tune = {knob[1], knob[1] | knob[0]};
        end else if (!cmd.digit_selected) begin
          active_nxt = stash_r;
          mode_nxt   = rasc_pkg::MODE_IDLE;
          refresh    = 1'b1;
        end else begin
          rate_nxt     = rate1;
          deadline_nxt = dl1;
          if (fire) begin
            deadline_nxt = new_dl;
            refresh      = 1'b1;
            tune         = sign_of(rate1);
            if (mode_r == rasc_pkg::MODE_BOUNCE) begin
              rate_nxt = rate_bnc;
              tune     = sign_of(rate_bnc);
            end else if (mode_r == rasc_pkg::MODE_UP || mode_r == rasc_pkg::MODE_DOWN) begin
              // wrap at the limits, at most one of the two applies
              if (!rate1[RATE_W-1] && (rate1 != '0) && (s_freq >= hi_freq)) begin
                we    = 1'b1;
                wdata = lo_freq;
              end
              if (rate1[RATE_W-1] && (s_freq <= lo_freq)) begin
                we    = 1'b1;
                wdata = hi_freq;
              end
            end
          end
        end
      end
      rasc_pkg::OP_START: begin
        if (!cmd.digit_selected) begin
          if (mode_r != rasc_pkg::MODE_IDLE) begin
            mode_nxt = rasc_pkg::MODE_IDLE;
            refresh  = 1'b1;
          end
        end else begin
          rate_nxt = '0;
          if (cmd.scan_mode == rasc_pkg::MODE_SIMPLE) begin
            go = 1'b1;
          end else if (cmd.scan_mode == rasc_pkg::MODE_UP ||
                       cmd.scan_mode == rasc_pkg::MODE_DOWN ||
                       cmd.scan_mode == rasc_pkg::MODE_BOUNCE ||
                       cmd.scan_mode == rasc_pkg::MODE_IDLE) begin
            if (cmd.scan_mode == rasc_pkg::MODE_IDLE || a_freq == b_freq) begin
              if (mode_r != rasc_pkg::MODE_IDLE) begin
                active_nxt = stash_r;
                mode_nxt   = rasc_pkg::MODE_IDLE;
                refresh    = 1'b1;
              end
            end else begin
              lo_b_nxt = !(a_freq < b_freq);
              hi_b_nxt = a_freq < b_freq;
              go       = 1'b1;
            end
          end
          if (go) begin
            stash_nxt  = active_r;
            we         = 1'b1;
            waddr      = VFO_S;
            wdata      = act_freq;
            active_nxt = VFO_S;
            rate_nxt   = start_rate;
            mode_nxt   = cmd.scan_mode;
            accepted   = 1'b1;
          end
        end
      end
      rasc_pkg::OP_STOP: begin
        if (mode_r != rasc_pkg::MODE_IDLE) begin
          case (cmd.stop_target)
            rasc_pkg::TGT_KEEP: begin
              we         = 1'b1;
              waddr      = stash_r;
              wdata      = act_freq;
              active_nxt = stash_r;
            end
            rasc_pkg::TGT_PREV: begin
              active_nxt = stash_r;
            end
            default: begin
              if (32'(tgt_off) < 32'(NUM_VFOS)) active_nxt = IDX_W'(tgt_off);
            end
          endcase
          mode_nxt = rasc_pkg::MODE_IDLE;
          refresh  = 1'b1;
        end
      end
      rasc_pkg::OP_WRITE: begin
        if (32'(cmd.vfo_index) < 32'(NUM_VFOS)) begin
          we    = 1'b1;
          waddr = IDX_W'(cmd.vfo_index);
          wdata = cmd.freq;
        end
      end
      rasc_pkg::OP_SELECT: begin
        if (32'(cmd.vfo_index) < 32'(NUM_VFOS)) active_nxt = IDX_W'(cmd.vfo_index);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.tune_dir   = tune;
    res.active_vfo = active_nxt[1:0];
    res.mode_now   = mode_nxt;
    res.scan_freq  = (we && waddr == VFO_S) ? wdata : s_freq;
    res.refresh    = refresh;
    res.accepted   = accepted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VFOS; i++) freq_r[i] <= 32'd0;
      active_r   <= '0;
      stash_r    <= '0;
      lo_b_r     <= 1'b0;
      hi_b_r     <= 1'b0;
      mode_r     <= rasc_pkg::MODE_IDLE;
      rate_r     <= '0;
      deadline_r <= 32'd0;
    end else if (step_en) begin
      if (we) freq_r[waddr] <= wdata;
      active_r   <= active_nxt;
      stash_r    <= stash_nxt;
      lo_b_r     <= lo_b_nxt;
      hi_b_r     <= hi_b_nxt;
      mode_r     <= mode_nxt;
      rate_r     <= rate_nxt;
      deadline_r <= deadline_nxt;
    end
  end

endmodule

[rtl/rasc_out_stage.sv]
// result register: packs the result struct onto the output stream
module rasc_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  rasc_pkg::res_t                  res,
  output logic                            can_load,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rasc_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic                            valid_r;
  logic                            valid_nxt;
  logic [rasc_pkg::OUT_DATA_W-1:0] data_r;
  logic [rasc_pkg::OUT_DATA_W-1:0] data_nxt;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    data_nxt  = {7'd0, res.accepted, res.refresh, res.scan_freq,
                 res.mode_now, res.active_vfo, res.tune_dir};
    valid_nxt = load || (valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule
